// ===== rtl/core/cqc_pkg.sv =====
// Shared types, widths and helper functions for the concyclic quad classifier.
// Depends on nothing; every module of the block imports it.
package cqc_pkg;

  // Bits per grid coordinate. The datapath widths below follow from it.
  localparam int COORD_WIDTH = 8;

  localparam int NUM_PTS      = 4;
  localparam int NUM_AXES     = 3;
  localparam int NUM_PAIRS    = 6;
  localparam int NUM_PAIRINGS = 3;

  // Exact widths of every intermediate quantity.
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int CSQ_W   = 2 * COORD_WIDTH;
  localparam int NORM_W  = 2 * COORD_WIDTH + 2;
  localparam int DIST_W  = 2 * DIFF_W;
  localparam int CROSS_W = 2 * COORD_WIDTH + 3;
  localparam int RHS_W   = NORM_W + 1;
  localparam int DTERM_W = DIFF_W + CROSS_W;
  localparam int DET_W   = DTERM_W + 2;
  localparam int PTERM_W = CROSS_W + RHS_W;
  localparam int DOT_W   = PTERM_W + 2;

  // The three ways to split the four points into two pairs {a,b} and {c,e}.
  localparam logic [1:0] PAIRINGS [NUM_PAIRINGS][NUM_PTS] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };

  typedef logic        [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic        [CSQ_W-1:0]       csq_t;
  typedef logic        [NORM_W-1:0]      norm_t;
  typedef logic        [DIST_W-1:0]      dist_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic signed [RHS_W-1:0]       rhs_t;
  typedef logic signed [DTERM_W-1:0]     dterm_t;
  typedef logic signed [DET_W-1:0]       det_t;
  typedef logic signed [PTERM_W-1:0]     pterm_t;
  typedef logic signed [DOT_W-1:0]       dot_t;

  typedef diff_t  [NUM_AXES-1:0] dvec_t;
  typedef cross_t [NUM_AXES-1:0] cvec_t;

  // Input item: four points, three coordinates each.
  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
  } in_t;

  // Result item.
  typedef struct packed {
    logic is_concyclic;
    logic is_symmetric;
  } out_t;

  // Stage 1: all pairwise difference vectors and the squared coordinates.
  typedef struct packed {
    dvec_t [NUM_PAIRS-1:0]                 dv;
    csq_t  [NUM_PTS-1:0][NUM_AXES-1:0]     csq;
  } s1_t;

  // Stage 2: minors, left-kernel candidates, norm differences, distances.
  typedef struct packed {
    dvec_t                   d0;
    cvec_t                   mnr;
    cvec_t [NUM_AXES-1:0]    nu_c;
    rhs_t  [NUM_AXES-1:0]    rhs;
    dist_t [NUM_PAIRS-1:0]   pair_dist;
  } s2_t;

  // Stage 3: products awaiting their final sums, plus the resolved flags.
  typedef struct packed {
    dterm_t [NUM_AXES-1:0] dterm;
    pterm_t [NUM_AXES-1:0] pterm;
    logic                  nu_nz;
    logic                  sym;
  } s3_t;

  // Index of the unordered point pair {a,b}: 01,02,03,12,13,23 map to 0..5.
  function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == 2'd0) begin
      return 3'(hi) - 3'd1;
    end
    return 3'(lo) + 3'(hi);
  endfunction

  // Cross product of two difference vectors, exact in CROSS_W bits.
  function automatic cvec_t cross3(input dvec_t u, input dvec_t v);
    cvec_t r;
    r[0] = cross_t'(u[1] * v[2]) - cross_t'(u[2] * v[1]);
    r[1] = cross_t'(u[2] * v[0]) - cross_t'(u[0] * v[2]);
    r[2] = cross_t'(u[0] * v[1]) - cross_t'(u[1] * v[0]);
    return r;
  endfunction

  // Square of one signed difference; the result is never negative.
  function automatic dist_t diff_sq(input diff_t d);
    logic signed [DIST_W-1:0] s;
    s = d * d;
    return dist_t'(s);
  endfunction

endpackage

// ===== rtl/core/cqc_diff.sv =====
// First pipeline stage: pairwise coordinate differences and coordinate squares.
// Depends on cqc_pkg.
module cqc_diff (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  cqc_pkg::in_t data_i,
  output logic         valid_o,
  output cqc_pkg::s1_t data_o
);
  import cqc_pkg::*;

  coord_t pt [NUM_PTS][NUM_AXES];
  s1_t    s1_d;
  s1_t    s1_q;
  logic   valid_q;

  // Unpack the item into a point array.
  always_comb begin
    pt[0][0] = data_i.p0_x;
    pt[0][1] = data_i.p0_y;
    pt[0][2] = data_i.p0_z;
    pt[1][0] = data_i.p1_x;
    pt[1][1] = data_i.p1_y;
    pt[1][2] = data_i.p1_z;
    pt[2][0] = data_i.p2_x;
    pt[2][1] = data_i.p2_y;
    pt[2][2] = data_i.p2_z;
    pt[3][0] = data_i.p3_x;
    pt[3][1] = data_i.p3_y;
    pt[3][2] = data_i.p3_z;
  end

  // Difference vectors p_b - p_a for every pair a < b, and per-axis squares.
  always_comb begin
    s1_d = '0;
    for (int a = 0; a < NUM_PTS; a++) begin
      for (int b = a + 1; b < NUM_PTS; b++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          s1_d.dv[pair_idx(2'(a), 2'(b))][j] =
            $signed({1'b0, pt[b][j]}) - $signed({1'b0, pt[a][j]});
        end
      end
    end
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        s1_d.csq[i][j] = csq_t'(pt[i][j] * pt[i][j]);
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s1_q;

endmodule

// ===== rtl/core/cqc_cross.sv =====
// Second pipeline stage: 2x2 minors, left-kernel candidates, norm differences
// and the six squared pair distances. Depends on cqc_pkg.
module cqc_cross (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  cqc_pkg::s1_t data_i,
  output logic         valid_o,
  output cqc_pkg::s2_t data_o
);
  import cqc_pkg::*;

  dvec_t                d1;
  dvec_t                d2;
  dvec_t [NUM_AXES-1:0] col;
  norm_t [NUM_PTS-1:0]  norm;
  s2_t                  s2_d;
  s2_t                  s2_q;
  logic                 valid_q;

  // Rows are the differences from point 0; columns are their per-axis slices.
  always_comb begin
    s2_d    = '0;
    s2_d.d0 = data_i.dv[pair_idx(2'd0, 2'd1)];
    d1      = data_i.dv[pair_idx(2'd0, 2'd2)];
    d2      = data_i.dv[pair_idx(2'd0, 2'd3)];
    for (int j = 0; j < NUM_AXES; j++) begin
      col[j][0] = s2_d.d0[j];
      col[j][1] = d1[j];
      col[j][2] = d2[j];
    end

    // Minors for the determinant, and the three kernel candidates in priority order.
    s2_d.mnr     = cross3(d1, d2);
    s2_d.nu_c[0] = cross3(col[0], col[1]);
    s2_d.nu_c[1] = cross3(col[0], col[2]);
    s2_d.nu_c[2] = cross3(col[1], col[2]);

    // Squared norms and their differences from point 0.
    for (int i = 0; i < NUM_PTS; i++) begin
      norm[i] = norm_t'(data_i.csq[i][0]) + norm_t'(data_i.csq[i][1])
              + norm_t'(data_i.csq[i][2]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      s2_d.rhs[i] = $signed({1'b0, norm[i+1]}) - $signed({1'b0, norm[0]});
    end

    // Squared distance of every point pair.
    for (int k = 0; k < NUM_PAIRS; k++) begin
      s2_d.pair_dist[k] = diff_sq(data_i.dv[k][0]) + diff_sq(data_i.dv[k][1])
                        + diff_sq(data_i.dv[k][2]);
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;

endmodule

// ===== rtl/core/cqc_decide.sv =====
// Third and fourth pipeline stages: products, kernel selection, mirror test,
// then the final sums and the output register. Depends on cqc_pkg.
module cqc_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cqc_pkg::s2_t  data_i,
  output logic          valid_o,
  output cqc_pkg::out_t data_o
);
  import cqc_pkg::*;

  cvec_t                nu_sel;
  logic [NUM_AXES-1:0]  nz;
  s3_t                  s3_d;
  s3_t                  s3_q;
  logic                 v3_q;
  det_t                 det;
  dot_t                 dot;
  out_t                 out_d;
  out_t                 out_q;
  logic                 valid_q;

  // Mirror test for one pairing {a,b},{c,e}: equal pair lengths or a kite.
  function automatic logic mirror_ok(input dist_t [NUM_PAIRS-1:0] pair_dist,
                                     input logic [1:0] a, input logic [1:0] b,
                                     input logic [1:0] c, input logic [1:0] e);
    logic trap;
    logic kite_ce;
    logic kite_ab;
    trap    = pair_dist[pair_idx(a, b)] == pair_dist[pair_idx(c, e)];
    kite_ce = (pair_dist[pair_idx(c, a)] == pair_dist[pair_idx(c, b)]) &&
              (pair_dist[pair_idx(e, a)] == pair_dist[pair_idx(e, b)]);
    kite_ab = (pair_dist[pair_idx(a, c)] == pair_dist[pair_idx(a, e)]) &&
              (pair_dist[pair_idx(b, c)] == pair_dist[pair_idx(b, e)]);
    return trap | kite_ce | kite_ab;
  endfunction

  // Stage 3: determinant terms, first nonzero kernel candidate times the
  // norm differences, and the symmetry flag.
  always_comb begin
    s3_d = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      nz[k] = |data_i.nu_c[k];
    end
    if (nz[0]) begin
      nu_sel = data_i.nu_c[0];
    end else if (nz[1]) begin
      nu_sel = data_i.nu_c[1];
    end else begin
      nu_sel = data_i.nu_c[2];
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      s3_d.dterm[i] = dterm_t'(data_i.d0[i]) * dterm_t'(data_i.mnr[i]);
      s3_d.pterm[i] = pterm_t'(nu_sel[i]) * pterm_t'(data_i.rhs[i]);
    end
    s3_d.nu_nz = |nz;
    for (int m = 0; m < NUM_PAIRINGS; m++) begin
      if (mirror_ok(data_i.pair_dist, PAIRINGS[m][0], PAIRINGS[m][1],
                    PAIRINGS[m][2], PAIRINGS[m][3])) begin
        s3_d.sym = 1'b1;
      end
    end
  end

  // Stage 4: sum the terms and form the flags. Collinear sets have no kernel.
  always_comb begin
    det = det_t'(s3_q.dterm[0]) + det_t'(s3_q.dterm[1]) + det_t'(s3_q.dterm[2]);
    dot = dot_t'(s3_q.pterm[0]) + dot_t'(s3_q.pterm[1]) + dot_t'(s3_q.pterm[2]);
    out_d.is_concyclic = (det == '0) && s3_q.nu_nz && (dot == '0);
    out_d.is_symmetric = s3_q.sym;
  end

  // Valid bits of stage 3 and of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v3_q    <= valid_i;
      valid_q <= v3_q;
    end
  end

  // Payload registers of stage 3 and of the output.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q  <= s3_d;
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

  // Without any nonzero kernel candidate the set can never be reported concyclic.
  a_no_kernel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v3_q && !s3_q.nu_nz) |=> !out_q.is_concyclic)
    else $error("concyclic flag set without a kernel vector");

  // The symmetry flag found in stage 3 reaches the output unchanged.
  a_sym_carry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v3_q && s3_q.sym) |=> out_q.is_symmetric)
    else $error("symmetry flag lost between stages");

  // An advancing pipeline moves the stage 3 valid bit into the output.
  a_valid_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (valid_q == $past(v3_q)))
    else $error("output valid does not follow stage 3");

  // A frozen pipeline keeps a held result intact.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_i && valid_q) |=> (valid_q && (out_q == $past(out_q))))
    else $error("held result changed during a stall");

endmodule

// ===== rtl/core/concyclic_quad_classifier.sv =====
// Top level of the concyclic quad classifier: handshake control and the
// four-stage datapath. Depends on cqc_pkg, cqc_diff, cqc_cross and cqc_decide.
//
// The block tests four integer 3D grid points and returns two flags per item:
// is_concyclic (the points lie on one circle; collinear sets give 0) and
// is_symmetric (an equal-length pairing or a kite mirror exists). It keeps no
// state between items. Every item passes four register stages (difference
// stage, minor stage, product stage, sum and output register) before its
// result is valid at the output. A new item can be taken in every cycle
// unless a result is stalled at the output, so the sustained rate is one item
// per clock while results are taken. All stages share one advance enable
// that is set by the output register: while a result waits to be taken the
// whole pipe holds, otherwise it moves, so input ready stays high as long as
// the output register is empty or being drained in the same cycle.
module concyclic_quad_classifier (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cqc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cqc_pkg::out_t out_data_o
);
  import cqc_pkg::*;

  logic en;
  logic v1;
  logic v2;
  s1_t  s1;
  s2_t  s2;

  // The pipe advances unless a finished result is stalled at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cqc_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  cqc_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  cqc_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .data_i  (s2),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
